@@ src/page_frame_allocator_macros.svh @@
// Assertion macros used by the page frame allocator checker.
`ifndef PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define PFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pfa_pkg.sv @@
// Package with the types and constants of the page frame allocator.
package pfa_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int PID_BITS   = 8;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

  typedef enum logic [1:0] {
    REQ_COUNT   = 2'd0,
    REQ_ALLOC   = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_SPARE   = 2'd3
  } req_t;

  typedef struct packed {
    req_t       req_type;
    logic [7:0] process_id;
    logic [6:0] frames_wanted;
  } pfa_in_t;

  typedef struct packed {
    logic       frame_valid;
    logic [5:0] frame_index;
    logic [6:0] free_count;
    logic       last;
  } pfa_out_t;

  typedef struct packed {
    logic                set_en;
    logic [FRAME_W-1:0]  set_idx;
    logic [PID_BITS-1:0] set_pid;
    logic                clr_en;
    logic [FRAME_W-1:0]  clr_idx;
    logic                rd_en;
    logic [FRAME_W-1:0]  rd_idx;
  } pfa_tbl_cmd_t;

endpackage

@@ src/pfa_frame_table.sv @@
// Frame table: busy flags in flip-flops and the owner memory.
module pfa_frame_table
  import pfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfa_tbl_cmd_t          cmd,
  output logic [NUM_FRAMES-1:0] busy_bits,
  output logic [PID_BITS-1:0]   rd_owner
);

  logic [NUM_FRAMES-1:0] busy_r;
  logic [PID_BITS-1:0]   owner_mem [NUM_FRAMES];
  logic [PID_BITS-1:0]   rd_owner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      if (cmd.set_en) begin
        busy_r[cmd.set_idx] <= 1'b1;
      end
      if (cmd.clr_en) begin
        busy_r[cmd.clr_idx] <= 1'b0;
      end
    end
  end

  // The owner of a frame is only used while the frame is busy.
  always_ff @(posedge clk) begin
    if (cmd.set_en) begin
      owner_mem[cmd.set_idx] <= cmd.set_pid;
    end
    if (cmd.rd_en) begin
      rd_owner_r <= owner_mem[cmd.rd_idx];
    end
  end

  assign busy_bits = busy_r;
  assign rd_owner  = rd_owner_r;

endmodule

@@ src/pfa_seq.sv @@
// Sequencer that scans the frame table one frame per cycle.
module pfa_seq
  import pfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  pfa_in_t               in_data,
  output logic                  busy,
  output logic                  out_valid,
  output pfa_out_t              out_data,
  output pfa_tbl_cmd_t          cmd,
  input  logic [NUM_FRAMES-1:0] busy_bits,
  input  logic [PID_BITS-1:0]   rd_owner
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_REL,
    ST_REL_END
  } state_t;

  state_t              state_r, state_nxt;
  logic [FRAME_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic [CNT_W-1:0]    free_cnt_r, free_cnt_nxt;
  logic [PID_BITS-1:0] pid_r, pid_nxt;
  logic                pipe_v_r, pipe_v_nxt;
  logic [FRAME_W-1:0]  pipe_idx_r, pipe_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  pfa_out_t            out_data_r, out_data_nxt;
  logic [CNT_W-1:0]    take;
  logic [PID_BITS-1:0] pid_in;

  assign pid_in = in_data.process_id[PID_BITS-1:0];
  assign take   = (8'(in_data.frames_wanted) > 8'(free_cnt_r)) ?
                  free_cnt_r : CNT_W'(in_data.frames_wanted);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    left_nxt      = left_r;
    free_cnt_nxt  = free_cnt_r;
    pid_nxt       = pid_r;
    pipe_v_nxt    = 1'b0;
    pipe_idx_nxt  = pipe_idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    cmd           = '0;

    // Second stage of the release scan, in the cycle after the owner read is issued.
    if (pipe_v_r && busy_bits[pipe_idx_r] && (rd_owner == pid_r)) begin
      cmd.clr_en   = 1'b1;
      cmd.clr_idx  = pipe_idx_r;
      free_cnt_nxt = CNT_W'(free_cnt_r + 1'b1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_data.req_type)
            REQ_ALLOC: begin
              if (take == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{frame_valid: 1'b0, frame_index: 6'd0,
                                  free_count: 7'(free_cnt_r), last: 1'b1};
              end else begin
                state_nxt    = ST_ALLOC;
                idx_nxt      = FRAME_W'(NUM_FRAMES - 1);
                left_nxt     = take;
                free_cnt_nxt = CNT_W'(free_cnt_r - take);
                pid_nxt      = pid_in;
              end
            end
            REQ_RELEASE: begin
              state_nxt = ST_REL;
              idx_nxt   = '0;
              pid_nxt   = pid_in;
            end
            REQ_COUNT, REQ_SPARE: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{frame_valid: 1'b0, frame_index: 6'd0,
                                free_count: 7'(free_cnt_r), last: 1'b1};
            end
          endcase
        end
      end
      ST_ALLOC: begin
        idx_nxt = FRAME_W'(idx_r - 1'b1);
        if (!busy_bits[idx_r]) begin
          cmd.set_en    = 1'b1;
          cmd.set_idx   = idx_r;
          cmd.set_pid   = pid_r;
          left_nxt      = CNT_W'(left_r - 1'b1);
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{frame_valid: 1'b1, frame_index: 6'(idx_r),
                            free_count: 7'(free_cnt_r), last: (left_r == CNT_W'(1))};
          if (left_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REL: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_idx   = idx_r;
        pipe_v_nxt   = 1'b1;
        pipe_idx_nxt = idx_r;
        idx_nxt      = FRAME_W'(idx_r + 1'b1);
        if (idx_r == FRAME_W'(NUM_FRAMES - 1)) begin
          state_nxt = ST_REL_END;
        end
      end
      ST_REL_END: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{frame_valid: 1'b0, frame_index: 6'd0,
                          free_count: 7'(free_cnt_nxt), last: 1'b1};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_cnt_r  <= CNT_W'(NUM_FRAMES);
      pipe_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_cnt_r  <= free_cnt_nxt;
      pipe_v_r    <= pipe_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    left_r     <= left_nxt;
    pid_r      <= pid_nxt;
    pipe_idx_r <= pipe_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/page_frame_allocator.sv @@
// Top level of the page frame allocator.
//
//   Channel   Ports                      Handshake
//   request   start, in_data, busy       taken when start is high and busy is low
//   result    out_valid, out_data        one cycle per result, cannot be held off
//
// A count request gives its result in the cycle after it is taken and leaves busy low.
// An allocate request walks the busy flags from the top frame down, one frame per cycle,
// and ends with its last claimed frame; if it can claim none it answers as a count does.
// A release request reads the owner memory once per frame.
// Reset marks every frame free; the owner memory is not cleared since it is used only for
// busy frames.
module page_frame_allocator
  import pfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  pfa_in_t  in_data,
  output logic     busy,
  output logic     out_valid,
  output pfa_out_t out_data
);

  pfa_tbl_cmd_t          tbl_cmd;
  logic [NUM_FRAMES-1:0] busy_bits;
  logic [PID_BITS-1:0]   rd_owner;

  pfa_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (tbl_cmd),
    .busy_bits (busy_bits),
    .rd_owner  (rd_owner)
  );

  pfa_frame_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (tbl_cmd),
    .busy_bits (busy_bits),
    .rd_owner  (rd_owner)
  );

endmodule

@@ src/pfa_checker.sv @@
// Port checker for the page frame allocator and its bind statement.
`include "page_frame_allocator_macros.svh"

module pfa_checker
  import pfa_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input pfa_in_t  in_data,
  input logic     busy,
  input logic     out_valid,
  input pfa_out_t out_data
);

  `PFA_ASSERT_NEXT(a_count_answers, start && !busy && (in_data.req_type == REQ_COUNT || in_data.req_type == REQ_SPARE), out_valid && out_data.last && !out_data.frame_valid && !busy, "Count transaction did not answer in the next cycle.")
  `PFA_ASSERT_NOW(a_invalid_is_last, out_valid && !out_data.frame_valid, out_data.last && (out_data.frame_index == 6'd0), "Result without a frame is not a lone last result.")
  `PFA_ASSERT_NOW(a_more_means_frame, out_valid && !out_data.last, out_data.frame_valid, "Non-final result carries no frame.")
  `PFA_ASSERT_NOW(a_busy_until_last, out_valid && !out_data.last, busy, "Block went idle before the last result.")
  `PFA_ASSERT_NOW(a_count_range, out_valid, out_data.free_count <= 7'(NUM_FRAMES), "Free count exceeds the frame table size.")

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (.*);

@@ verif/testbench.sv @@
// Testbench for the page frame allocator: directed and random requests checked against a frame table model.
`timescale 1ns / 1ps

module testbench
  import pfa_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 2000;

  class frame_ledger;
    bit                  in_use [NUM_FRAMES];
    bit [PID_BITS-1:0]   owner  [NUM_FRAMES];
    pfa_out_t            expected_frames [$];
    int                  mismatch_count;

    function int free_frames();
      int n;
      n = 0;
      for (int f = 0; f < NUM_FRAMES; f++) begin
        if (!in_use[f]) n++;
      end
      return n;
    endfunction

    function int outstanding();
      return expected_frames.size();
    endfunction

    function void flag(string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", what);
    endfunction

    function void note_request(pfa_in_t req);
      pfa_out_t claimed [$];
      pfa_out_t res;
      int       left;
      int       n;
      left = req.frames_wanted;
      case (req.req_type)
        REQ_ALLOC: begin
          for (int f = NUM_FRAMES - 1; f >= 0 && left > 0; f--) begin
            if (!in_use[f]) begin
              in_use[f] = 1'b1;
              owner[f] = req.process_id[PID_BITS-1:0];
              res = '0;
              res.frame_valid = 1'b1;
              res.frame_index = 6'(f);
              claimed.push_back(res);
              left--;
            end
          end
        end
        REQ_RELEASE: begin
          for (int f = 0; f < NUM_FRAMES; f++) begin
            if (in_use[f] && owner[f] == req.process_id[PID_BITS-1:0]) begin
              in_use[f] = 1'b0;
              owner[f] = '0;
            end
          end
        end
        default: ;
      endcase
      if (claimed.size() == 0) begin
        res = '0;
        claimed.push_back(res);
      end
      n = claimed.size();
      foreach (claimed[k]) begin
        res = claimed[k];
        res.free_count = 7'(free_frames());
        res.last = (k == n - 1);
        expected_frames.push_back(res);
      end
    endfunction

    function void check_result(pfa_out_t seen);
      pfa_out_t want;
      if (expected_frames.size() == 0) begin
        flag($sformatf("unexpected result: valid=%0b index=%0d free=%0d last=%0b",
                       seen.frame_valid, seen.frame_index, seen.free_count, seen.last));
        return;
      end
      want = expected_frames.pop_front();
      if (seen.frame_valid !== want.frame_valid || seen.frame_index !== want.frame_index ||
          seen.free_count !== want.free_count || seen.last !== want.last) begin
        flag($sformatf("result mismatch: expected valid=%0b index=%0d free=%0d last=%0b, got valid=%0b index=%0d free=%0d last=%0b",
                       want.frame_valid, want.frame_index, want.free_count, want.last,
                       seen.frame_valid, seen.frame_index, seen.free_count, seen.last));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  pfa_in_t     in_data;
  logic        busy;
  logic        out_valid;
  pfa_out_t    out_data;

  frame_ledger ledger;
  int          idle_pct;
  bit          sending;
  int          idle_cycles;
  bit [7:0]    pid_pool [6] = '{8'h00, 8'h01, 8'h3C, 8'h80, 8'hA5, 8'hFF};

  page_frame_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) ledger.check_result(out_data);
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || out_valid === 1'b1) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic pfa_in_t request(req_t kind, bit [7:0] pid, bit [6:0] wanted);
    pfa_in_t r;
    r.req_type = kind;
    r.process_id = pid;
    r.frames_wanted = wanted;
    return r;
  endfunction

  function automatic pfa_in_t random_request();
    pfa_in_t r;
    int      pick;
    pick = $urandom_range(99);
    if (pick < 45) r.req_type = REQ_ALLOC;
    else if (pick < 75) r.req_type = REQ_RELEASE;
    else if (pick < 90) r.req_type = REQ_COUNT;
    else r.req_type = REQ_SPARE;
    r.process_id = pid_pool[$urandom_range(5)];
    if ($urandom_range(99) < (r.req_type == REQ_ALLOC ? 8 : 50)) r.process_id = 8'($urandom);
    r.frames_wanted = 7'($urandom_range(8, 1));
    if ($urandom_range(19) == 0) r.frames_wanted = 7'($urandom_range(127));
    return r;
  endfunction

  task automatic issue_request(input pfa_in_t req);
    int gap;
    sending = 1'b1;
    start <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    ledger.note_request(req);
    gap = 0;
    while (gap < 12 && $urandom_range(99) < idle_pct) gap++;
    if (idle_pct != 0 && $urandom_range(9) == 0) gap = $urandom_range(80, 1);
    if (gap > 0) begin
      sending = 1'b0;
      start <= 1'b0;
      in_data <= pfa_in_t'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    if (sending) begin
      sending = 1'b0;
      start <= 1'b0;
    end
    while (ledger.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    ledger = new;
    idle_pct = 0;
    sending = 1'b0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    issue_request(request(REQ_COUNT, 8'h00, 7'd0));
    issue_request(request(REQ_ALLOC, 8'h55, 7'd0));
    issue_request(request(REQ_ALLOC, 8'hFF, 7'd1));
    issue_request(request(REQ_ALLOC, 8'h00, 7'd5));
    issue_request(request(REQ_RELEASE, 8'hAA, 7'd0));
    issue_request(request(REQ_SPARE, 8'hFF, 7'd127));
    issue_request(request(REQ_ALLOC, 8'h80, 7'd127));
    issue_request(request(REQ_ALLOC, 8'h12, 7'd1));
    issue_request(request(REQ_COUNT, 8'hFF, 7'd64));
    issue_request(request(REQ_RELEASE, 8'h00, 7'd0));
    issue_request(request(REQ_ALLOC, 8'h01, 7'd64));
    issue_request(request(REQ_RELEASE, 8'h80, 7'd127));
    issue_request(request(REQ_RELEASE, 8'hFF, 7'd0));
    issue_request(request(REQ_RELEASE, 8'h01, 7'd0));
    issue_request(request(REQ_COUNT, 8'h00, 7'd0));
    issue_request(request(REQ_ALLOC, 8'h7F, 7'd64));
    issue_request(request(REQ_ALLOC, 8'h7F, 7'd0));
    issue_request(request(REQ_RELEASE, 8'h7F, 7'd0));
    issue_request(request(REQ_ALLOC, 8'h00, 7'd3));
    issue_request(request(REQ_ALLOC, 8'hFF, 7'd65));
    issue_request(request(REQ_RELEASE, 8'h00, 7'd0));
    issue_request(request(REQ_RELEASE, 8'hFF, 7'd0));
    drain_results();

    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 0 : (p == 1) ? 67 : 10;
      repeat (83) issue_request(random_request());
      drain_results();
    end

    repeat (NUM_FRAMES + 8) @(posedge clk);
    if (ledger.outstanding() != 0)
      ledger.flag($sformatf("%0d expected results never arrived", ledger.outstanding()));
    if (ledger.mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ page_frame_allocator.f @@
+incdir+src
src/pfa_pkg.sv
src/pfa_frame_table.sv
src/pfa_seq.sv
src/page_frame_allocator.sv
src/pfa_checker.sv
verif/testbench.sv
